/* sv/clmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Client liveness mode tracker package
// Operation codes, mode codes and shared sizes.
// ----------------------------------------------------------------------------
package clmt_pkg;

    localparam int unsigned SLOTS_DEF = 16;
    localparam logic [31:0] TIMEOUT_RST = 32'd1000;

    typedef enum logic [2:0] {
        OP_ENABLE  = 3'd0,
        OP_OPEN    = 3'd1,
        OP_HELLO   = 3'd2,
        OP_STATE   = 3'd3,
        OP_GOODBYE = 3'd4,
        OP_FAILURE = 3'd5,
        OP_TICK    = 3'd6,
        OP_NONE    = 3'd7
    } t_op;

    localparam logic [2:0] MODE_DISABLED     = 3'd0;
    localparam logic [2:0] MODE_DISCONNECTED = 3'd1;
    localparam logic [2:0] MODE_AWAITING     = 3'd2;
    localparam logic [2:0] MODE_SENSITIVE    = 3'd3;
    localparam logic [2:0] MODE_SAFE         = 3'd4;

endpackage

/* sv/clmt_slot_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table memory
// One write port and one registered read port for the per-slot words.
// ----------------------------------------------------------------------------
module clmt_slot_ram #(
    parameter int unsigned SLOTS = 16,
    parameter int unsigned AW = 4,
    parameter int unsigned DW = 164
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* sv/client_liveness_mode_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Client liveness mode tracker
// Session table with one sequencer that walks the slots for every word.
// ----------------------------------------------------------------------------
// Each word walks the slot table through the single read port of the slot
// memory, reading each slot and then processing it: one pass for lookup,
// free slot search and expiry, then one pass that aggregates the mode, plus
// an apply state and an output state. The result is strobed after the output
// state and busy stays high through it, so a new word is taken only once
// the strobe is over. A hello adds a duplicate identity pass before the
// apply state. The result is held for one cycle under o_done and cannot be
// stalled.
module client_liveness_mode_tracker #(
    parameter int unsigned SLOTS = clmt_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_connection,
    input  logic [31:0] i_client_ident,
    input  logic [63:0] i_sequence_req,
    input  logic        i_sensitive_flag,
    input  logic [31:0] i_now,
    input  logic        i_enable_value,
    output logic        o_done,
    output logic        o_accepted,
    output logic [31:0] o_assigned_connection,
    output logic [2:0]  o_guard_mode
);
    import clmt_pkg::*;

    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DEC   = 6'b000100,
        S_APPLY = 6'b001000,
        S_MODE  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    // slot word: conn, hello, ident, seq_seen, last_seq, state_known, sens, update time
    typedef struct packed {
        logic [31:0] conn;
        logic        hello;
        logic [31:0] ident;
        logic        seq_seen;
        logic [63:0] last_seq;
        logic        known;
        logic        sens;
        logic [31:0] upd;
    } t_slot;

    localparam int unsigned DW = $bits(t_slot);

    t_state r_state, n_state;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [SLOTS-1:0] r_known, n_known;
    logic [CW-1:0] r_idx, n_idx;
    logic r_rd, n_rd;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic r_guard, n_guard;
    logic [7:0] r_lost, n_lost;
    logic r_latch, n_latch;
    logic [31:0] r_next, n_next;
    logic [31:0] r_timeout;
    logic [2:0] r_op;
    logic [31:0] r_conn, r_ident, r_now;
    logic [63:0] r_seq;
    logic r_sens, r_en;
    logic r_found, n_found;
    logic [AW-1:0] r_fidx, n_fidx;
    t_slot r_fslot, n_fslot;
    logic r_free, n_free;
    logic [AW-1:0] r_freeidx, n_freeidx;
    logic r_dup, n_dup;
    logic r_await, n_await;
    logic r_anys, n_anys;
    logic r_acc, n_acc;
    logic [31:0] r_asg, n_asg;
    logic [2:0] r_mode, n_mode;
    logic r_done;

    logic          we;
    logic [AW-1:0] waddr;
    t_slot         wslot;
    logic [DW-1:0] rdata;
    t_slot         rs;
    logic [31:0]   age;

    assign rs = t_slot'(rdata);
    assign age = r_now - rs.upd;

    clmt_slot_ram #(.SLOTS(SLOTS), .AW(AW), .DW(DW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(DW'(wslot)),
        .i_raddr(n_rd_idx),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
        if (start && !busy) begin
            r_op <= i_operation;
            r_conn <= i_connection;
            r_ident <= i_client_ident;
            r_seq <= i_sequence_req;
            r_sens <= i_sensitive_flag;
            r_now <= i_now;
            r_en <= i_enable_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_known <= '0;
            r_guard <= 1'b0;
            r_lost <= 8'd0;
            r_latch <= 1'b0;
            r_next <= 32'd0;
            r_done <= 1'b0;
            r_rd <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_known <= n_known;
            r_guard <= n_guard;
            r_lost <= n_lost;
            r_latch <= n_latch;
            r_next <= n_next;
            r_done <= (r_state == S_OUT);
            r_rd <= n_rd;
        end
        r_idx <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_found <= n_found;
        r_fidx <= n_fidx;
        r_fslot <= n_fslot;
        r_free <= n_free;
        r_freeidx <= n_freeidx;
        r_dup <= n_dup;
        r_await <= n_await;
        r_anys <= n_anys;
        r_acc <= n_acc;
        r_asg <= n_asg;
        r_mode <= n_mode;
    end

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_known = r_known;
        n_guard = r_guard;
        n_lost = r_lost;
        n_latch = r_latch;
        n_next = r_next;
        n_idx = r_idx;
        n_rd = 1'b0;
        n_rd_idx = r_rd_idx;
        n_found = r_found;
        n_fidx = r_fidx;
        n_fslot = r_fslot;
        n_free = r_free;
        n_freeidx = r_freeidx;
        n_dup = r_dup;
        n_await = r_await;
        n_anys = r_anys;
        n_acc = r_acc;
        n_asg = r_asg;
        n_mode = r_mode;
        we = 1'b0;
        waddr = r_rd_idx;
        wslot = rs;
        case (r_state)
            S_IDLE: begin
                if (start && !busy) begin
                    n_state = S_SCAN;
                    n_idx = '0;
                    n_rd = 1'b1;
                    n_rd_idx = '0;
                    n_found = 1'b0;
                    n_free = 1'b0;
                    n_dup = 1'b0;
                    n_acc = 1'b0;
                    n_asg = 32'd0;
                end
            end
            S_SCAN: begin
                // Lookup by connection, free slot search and expiry in one pass.
                if (r_rd) begin
                    if (!r_valid[r_rd_idx] && !r_free) begin
                        n_free = 1'b1;
                        n_freeidx = r_rd_idx;
                    end
                    if (r_valid[r_rd_idx] && rs.conn == r_conn && !r_found) begin
                        n_found = 1'b1;
                        n_fidx = r_rd_idx;
                        n_fslot = rs;
                    end
                    if (r_op == OP_TICK && r_valid[r_rd_idx] && age > r_timeout) begin
                        n_valid[r_rd_idx] = 1'b0;
                        if (r_known[r_rd_idx]) begin
                            if (n_lost != 8'd255) begin
                                n_lost = n_lost + 8'd1;
                            end
                        end else begin
                            n_latch = 1'b1;
                        end
                    end
                    n_idx = r_idx + CW'(1);
                    if (r_idx == CW'(SLOTS - 1)) begin
                        n_state = (r_op == OP_HELLO) ? S_DEC : S_APPLY;
                        n_idx = '0;
                        n_rd = (r_op == OP_HELLO);
                        n_rd_idx = '0;
                    end
                end else begin
                    n_rd = 1'b1;
                    n_rd_idx = r_idx[AW-1:0];
                end
            end
            S_DEC: begin
                // Duplicate identity check for hello.
                if (r_rd) begin
                    if (!(r_found && r_rd_idx == r_fidx) && r_valid[r_rd_idx] && rs.hello
                            && rs.ident == r_ident) begin
                        n_dup = 1'b1;
                    end
                    n_idx = r_idx + CW'(1);
                    if (r_idx == CW'(SLOTS - 1)) begin
                        n_state = S_APPLY;
                    end
                end else begin
                    n_rd = 1'b1;
                    n_rd_idx = r_idx[AW-1:0];
                end
            end
            S_APPLY: begin
                n_state = S_MODE;
                n_idx = '0;
                n_rd = 1'b0;
                waddr = r_fidx;
                wslot = r_fslot;
                wslot.upd = r_now;
                case (r_op)
                    OP_ENABLE: begin
                        if (r_en != r_guard) begin
                            n_guard = r_en;
                            if (r_en) begin
                                n_lost = 8'd0;
                                n_latch = 1'b0;
                                n_known = '0;
                            end
                        end
                    end
                    OP_OPEN: begin
                        if (r_free) begin
                            we = 1'b1;
                            waddr = r_freeidx;
                            wslot = '0;
                            wslot.conn = r_next;
                            wslot.upd = r_now;
                            n_valid[r_freeidx] = 1'b1;
                            n_known[r_freeidx] = 1'b0;
                            n_asg = r_next;
                            n_next = r_next + 32'd1;
                            n_acc = 1'b1;
                        end
                    end
                    OP_HELLO: begin
                        if (r_found && !r_fslot.hello && !r_dup) begin
                            we = 1'b1;
                            wslot.ident = r_ident;
                            wslot.hello = 1'b1;
                            n_acc = 1'b1;
                        end
                    end
                    OP_STATE: begin
                        if (r_found && r_fslot.hello
                                && !(r_fslot.seq_seen && r_seq <= r_fslot.last_seq)) begin
                            we = 1'b1;
                            wslot.seq_seen = 1'b1;
                            wslot.last_seq = r_seq;
                            wslot.sens = r_sens;
                            n_known[r_fidx] = 1'b1;
                            n_latch = 1'b0;
                            if (!r_known[r_fidx] && r_lost != 8'd0) begin
                                n_lost = r_lost - 8'd1;
                            end
                            n_acc = 1'b1;
                        end
                    end
                    OP_GOODBYE: begin
                        if (r_found && r_fslot.hello) begin
                            n_valid[r_fidx] = 1'b0;
                            n_acc = 1'b1;
                        end
                    end
                    OP_FAILURE: begin
                        if (r_found) begin
                            n_valid[r_fidx] = 1'b0;
                            if (r_known[r_fidx]) begin
                                if (r_lost != 8'd255) begin
                                    n_lost = r_lost + 8'd1;
                                end
                            end else begin
                                n_latch = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                n_await = 1'b0;
                n_anys = 1'b0;
            end
            S_MODE: begin
                // Aggregate over live slots; sensitive flags come from memory.
                if (r_rd) begin
                    if (r_valid[r_rd_idx]) begin
                        if (!rs.hello || !r_known[r_rd_idx]) begin
                            n_await = 1'b1;
                        end
                        if (rs.sens) begin
                            n_anys = 1'b1;
                        end
                    end
                    n_idx = r_idx + CW'(1);
                    if (r_idx == CW'(SLOTS - 1)) begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_rd = 1'b1;
                    n_rd_idx = r_idx[AW-1:0];
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
                if (!r_guard) begin
                    n_mode = MODE_DISABLED;
                end else if (r_latch || r_lost != 8'd0) begin
                    n_mode = MODE_DISCONNECTED;
                end else if (r_valid == '0 || r_await) begin
                    n_mode = MODE_AWAITING;
                end else if (r_anys) begin
                    n_mode = MODE_SENSITIVE;
                end else begin
                    n_mode = MODE_SAFE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE) || r_done;
    assign o_done = r_done;
    assign o_accepted = r_acc;
    assign o_assigned_connection = r_asg;
    assign o_guard_mode = r_mode;
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Client liveness mode tracker testbench
// Drives directed and random session events through the start/busy port,
// predicts every result with a scoreboard that mirrors the session table and
// checks each result word field by field as it is strobed out under o_done.
// ----------------------------------------------------------------------------
module tb_top;
    import clmt_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        t_op         op;
        logic [31:0] conn;
        logic [31:0] ident;
        logic [63:0] seq;
        logic        sens;
        logic [31:0] now;
        logic        en;
    } t_session_word;

    typedef struct {
        logic        accepted;
        logic [31:0] assigned;
        logic [2:0]  mode;
    } t_mode_result;

    class liveness_scoreboard;
        bit          valid[NSLOT];
        bit [31:0]   conn[NSLOT];
        bit          hello[NSLOT];
        bit [31:0]   ident[NSLOT];
        bit          seq_seen[NSLOT];
        bit [63:0]   last_seq[NSLOT];
        bit          known[NSLOT];
        bit          sens[NSLOT];
        bit [31:0]   upd[NSLOT];
        bit          enabled;
        bit [7:0]    lost;
        bit          latch;
        bit [31:0]   next_id;
        bit [31:0]   timeout;
        t_mode_result expected_q[$];
        int          mismatches;
        int          checked;
        int          accepted_seen;

        function new();
            timeout = TIMEOUT_RST;
        endfunction

        function int find(bit [31:0] c);
            for (int i = 0; i < NSLOT; i++) begin
                if (valid[i] && conn[i] == c) return i;
            end
            return -1;
        endfunction

        function void drop(int s);
            if (known[s]) begin
                if (lost != 8'd255) lost++;
            end else begin
                latch = 1'b1;
            end
            valid[s] = 1'b0;
        endfunction

        function logic [2:0] mode();
            bit any_live;
            bit any_sens;
            any_live = 0;
            any_sens = 0;
            if (!enabled) return MODE_DISABLED;
            if (latch || lost != 0) return MODE_DISCONNECTED;
            for (int i = 0; i < NSLOT; i++) begin
                if (valid[i]) begin
                    any_live = 1;
                    if (!hello[i] || !known[i]) return MODE_AWAITING;
                    if (sens[i]) any_sens = 1;
                end
            end
            if (!any_live) return MODE_AWAITING;
            return any_sens ? MODE_SENSITIVE : MODE_SAFE;
        endfunction

        function void note(t_session_word w);
            t_mode_result r;
            int s;
            bit dup;
            bit first;
            bit [31:0] age;
            r.accepted = 0;
            r.assigned = 0;
            case (w.op)
                OP_ENABLE: begin
                    if (w.en != enabled) begin
                        enabled = w.en;
                        if (w.en) begin
                            lost = 0;
                            latch = 0;
                            for (int i = 0; i < NSLOT; i++) known[i] = 0;
                        end
                    end
                end
                OP_OPEN: begin
                    s = -1;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!valid[i] && s < 0) s = i;
                    end
                    if (s >= 0) begin
                        valid[s] = 1;
                        conn[s] = next_id;
                        hello[s] = 0;
                        ident[s] = 0;
                        seq_seen[s] = 0;
                        last_seq[s] = 0;
                        known[s] = 0;
                        sens[s] = 0;
                        upd[s] = w.now;
                        r.assigned = next_id;
                        next_id = next_id + 1;
                        r.accepted = 1;
                    end
                end
                OP_HELLO: begin
                    s = find(w.conn);
                    if (s >= 0 && !hello[s]) begin
                        dup = 0;
                        for (int i = 0; i < NSLOT; i++) begin
                            if (i != s && valid[i] && hello[i] && ident[i] == w.ident) dup = 1;
                        end
                        if (!dup) begin
                            ident[s] = w.ident;
                            hello[s] = 1;
                            upd[s] = w.now;
                            r.accepted = 1;
                        end
                    end
                end
                OP_STATE: begin
                    s = find(w.conn);
                    if (s >= 0 && hello[s] && !(seq_seen[s] && w.seq <= last_seq[s])) begin
                        first = !known[s];
                        seq_seen[s] = 1;
                        last_seq[s] = w.seq;
                        known[s] = 1;
                        sens[s] = w.sens;
                        upd[s] = w.now;
                        latch = 0;
                        if (first && lost > 0) lost--;
                        r.accepted = 1;
                    end
                end
                OP_GOODBYE: begin
                    s = find(w.conn);
                    if (s >= 0 && hello[s]) begin
                        valid[s] = 0;
                        r.accepted = 1;
                    end
                end
                OP_FAILURE: begin
                    s = find(w.conn);
                    if (s >= 0) drop(s);
                end
                OP_TICK: begin
                    for (int i = 0; i < NSLOT; i++) begin
                        age = w.now - upd[i];
                        if (valid[i] && age > timeout) drop(i);
                    end
                end
                default: ;
            endcase
            r.mode = mode();
            expected_q.push_back(r);
        endfunction

        function void check(logic acc, logic [31:0] asg, logic [2:0] m);
            t_mode_result e;
            checked++;
            if (acc === 1'b1) accepted_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: accepted=%0b assigned=%0d mode=%0d",
                             acc, asg, m);
                return;
            end
            e = expected_q.pop_front();
            if (acc !== e.accepted || asg !== e.assigned || m !== e.mode) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected acc=%0b asg=%0d mode=%0d, ",
                              "got acc=%0b asg=%0d mode=%0d"},
                             e.accepted, e.assigned, e.mode, acc, asg, m);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic [2:0]  i_operation;
    logic [31:0] i_connection;
    logic [31:0] i_client_ident;
    logic [63:0] i_sequence_req;
    logic        i_sensitive_flag;
    logic [31:0] i_now;
    logic        i_enable_value;
    logic        o_done;
    logic        o_accepted;
    logic [31:0] o_assigned_connection;
    logic [2:0]  o_guard_mode;

    liveness_scoreboard sb;
    int          words_sent;
    int          idle_cycles;
    logic [31:0] clock_now;
    logic [63:0] seq_base;

    client_liveness_mode_tracker dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_operation           (i_operation),
        .i_connection          (i_connection),
        .i_client_ident        (i_client_ident),
        .i_sequence_req        (i_sequence_req),
        .i_sensitive_flag      (i_sensitive_flag),
        .i_now                 (i_now),
        .i_enable_value        (i_enable_value),
        .o_done                (o_done),
        .o_accepted            (o_accepted),
        .o_assigned_connection (o_assigned_connection),
        .o_guard_mode          (o_guard_mode)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check(o_accepted, o_assigned_connection, o_guard_mode);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", sb.expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(t_session_word w);
        start            <= 1'b1;
        i_operation      <= w.op;
        i_connection     <= w.conn;
        i_client_ident   <= w.ident;
        i_sequence_req   <= w.seq;
        i_sensitive_flag <= w.sens;
        i_now            <= w.now;
        i_enable_value   <= w.en;
        do @(posedge i_clk); while (busy);
        sb.note(w);
        words_sent++;
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_and_set_timeout(logic [31:0] value);
        pause(1);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.timeout = value;
        @(posedge i_clk);
    endtask

    function automatic t_session_word make_word(t_op op, logic [31:0] conn,
                                                logic [31:0] ident, logic [63:0] seq,
                                                logic sens, logic [31:0] now, logic en);
        t_session_word w;
        w.op = op;
        w.conn = conn;
        w.ident = ident;
        w.seq = seq;
        w.sens = sens;
        w.now = now;
        w.en = en;
        return w;
    endfunction

    function automatic t_session_word random_word();
        t_session_word w;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6) w.op = OP_ENABLE;
        else if (pick < 26) w.op = OP_OPEN;
        else if (pick < 44) w.op = OP_HELLO;
        else if (pick < 70) w.op = OP_STATE;
        else if (pick < 78) w.op = OP_GOODBYE;
        else if (pick < 84) w.op = OP_FAILURE;
        else if (pick < 97) w.op = OP_TICK;
        else w.op = OP_NONE;
        if ($urandom_range(0, 9) == 0) w.conn = $urandom;
        else w.conn = sb.next_id - $urandom_range(1, 20);
        if ($urandom_range(0, 9) == 0) w.ident = $urandom;
        else w.ident = $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0) begin
            w.seq = {$urandom, $urandom};
        end else begin
            seq_base = seq_base + $urandom_range(0, 3);
            w.seq = seq_base;
        end
        w.sens = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 49) == 0) clock_now = $urandom;
        else clock_now = clock_now + $urandom_range(0, 120);
        w.now = clock_now;
        w.en = ($urandom_range(0, 3) != 0);
        return w;
    endfunction

    task automatic random_phase(int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
                send_word(random_word());
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 15));
        end
    endtask

    initial begin
        sb = new();
        words_sent = 0;
        idle_cycles = 0;
        clock_now = 0;
        seq_base = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_operation = OP_NONE;
        i_connection = '0;
        i_client_ident = '0;
        i_sequence_req = '0;
        i_sensitive_flag = 1'b0;
        i_now = '0;
        i_enable_value = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(make_word(OP_STATE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_ENABLE, 0, 0, 0, 0, 0, 1));
        send_word(make_word(OP_OPEN, 0, 0, 0, 0, 10, 0));
        send_word(make_word(OP_OPEN, 0, 0, 0, 0, 10, 0));
        send_word(make_word(OP_OPEN, 0, 0, 0, 0, 10, 0));
        send_word(make_word(OP_HELLO, 0, 32'hFFFF_FFFF, 0, 0, 20, 0));
        send_word(make_word(OP_HELLO, 1, 32'hFFFF_FFFF, 0, 0, 20, 0));
        send_word(make_word(OP_HELLO, 0, 5, 0, 0, 20, 0));
        send_word(make_word(OP_STATE, 0, 0, 64'd10, 1, 30, 0));
        send_word(make_word(OP_STATE, 0, 0, 64'd10, 0, 30, 0));
        send_word(make_word(OP_STATE, 0, 0, '1, 0, 30, 0));
        send_word(make_word(OP_STATE, 1, 0, 64'd1, 0, 30, 0));
        send_word(make_word(OP_GOODBYE, 1, 0, 0, 0, 30, 0));
        send_word(make_word(OP_GOODBYE, 32'hFFFF_FFFF, 0, 0, 0, 30, 0));
        send_word(make_word(OP_FAILURE, 2, 0, 0, 0, 30, 0));
        send_word(make_word(OP_HELLO, 1, 6, 0, 0, 40, 0));
        send_word(make_word(OP_STATE, 1, 0, 64'd0, 0, 40, 0));
        send_word(make_word(OP_TICK, 0, 0, 0, 0, 2000, 0));
        send_word(make_word(OP_ENABLE, 0, 0, 0, 0, 0, 1));
        send_word(make_word(OP_ENABLE, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_ENABLE, 0, 0, 0, 0, 0, 1));
        send_word(make_word(OP_NONE, '1, '1, '1, 1, '1, 1));
        send_word(make_word(OP_FAILURE, 32'h1234_5678, 0, 0, 0, 0, 0));
        for (int i = 0; i < 17; i++) send_word(make_word(OP_OPEN, 0, 0, 0, 0, '1, 0));
        clock_now = 32'hFFFF_FF00;

        drain_and_set_timeout(32'd0);
        random_phase(500);
        drain_and_set_timeout(32'hFFFF_FFFF);
        random_phase(500);
        drain_and_set_timeout(32'd200);
        random_phase(500);
        drain_and_set_timeout(TIMEOUT_RST);
        random_phase(500);

        pause(1);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Sent %0d words over four timeout settings including 0 and all ones.",
                 words_sent);
        $display("Checked %0d results, %0d accepted, %0d mismatches.",
                 sb.checked, sb.accepted_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/clmt_pkg.sv
sv/clmt_slot_ram.sv
sv/client_liveness_mode_tracker.sv
bench/tb_top.sv
